[rtl/tia_pkg.sv]
`default_nettype none
package tia_pkg;

  // command codes on the request port
  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_MOD = 4'd4,
    CMD_SHL = 4'd5,
    CMD_LT  = 4'd6,
    CMD_GT  = 4'd7,
    CMD_LE  = 4'd8
  } cmd_t;

  // classified operation carried from front to back
  typedef enum logic [3:0] {
    OP_FAIL,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_SHL,
    OP_LT,
    OP_GT,
    OP_LE
  } op_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_RUN,
    BK_MUL,
    BK_DIV,
    BK_FIX
  } bk_state_t;

  typedef struct packed {
    logic        [3:0]  cmd;
    logic signed [63:0] left_word;
    logic signed [63:0] right_word;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value_word;
    logic               truth;
    logic               failed;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] left;
    logic [63:0] right;
  } item_t;

  // restoring divider: one quotient bit per step over 63-bit magnitudes
  localparam int DIV_STEPS = 63;
  localparam int MUL_STEPS = 3;

endpackage
`default_nettype wire

[rtl/tia_front.sv]
`default_nettype none
module tia_front (
  input  wire tia_pkg::in_t   in_req,
  output tia_pkg::item_t      item
);

  logic lt_tag;
  logic rt_tag;
  logic div_zero;
  logic shift_ok;

  // tag and operand checks
  assign lt_tag   = in_req.left_word[0];
  assign rt_tag   = in_req.right_word[0];
  assign div_zero = (in_req.right_word[63:1] == 63'd0);
  assign shift_ok = (in_req.right_word[63:7] == 57'd0) && (in_req.right_word[6:1] != 6'd63);

  // classify request into the operation the back end runs
  always_comb begin
    item.left  = in_req.left_word;
    item.right = in_req.right_word;
    item.op    = tia_pkg::OP_FAIL;
    case (in_req.cmd)
      tia_pkg::CMD_ADD: item.op = (lt_tag && rt_tag) ? tia_pkg::OP_ADD : tia_pkg::OP_FAIL;
      tia_pkg::CMD_SUB: item.op = rt_tag ? tia_pkg::OP_SUB : tia_pkg::OP_FAIL;
      tia_pkg::CMD_MUL: item.op = (lt_tag && rt_tag) ? tia_pkg::OP_MUL : tia_pkg::OP_FAIL;
      tia_pkg::CMD_DIV: begin
        item.op = (lt_tag && rt_tag && !div_zero) ? tia_pkg::OP_DIV : tia_pkg::OP_FAIL;
      end
      tia_pkg::CMD_MOD: begin
        item.op = (lt_tag && rt_tag && !div_zero) ? tia_pkg::OP_MOD : tia_pkg::OP_FAIL;
      end
      tia_pkg::CMD_SHL: item.op = (rt_tag && shift_ok) ? tia_pkg::OP_SHL : tia_pkg::OP_FAIL;
      tia_pkg::CMD_LT:  item.op = rt_tag ? tia_pkg::OP_LT : tia_pkg::OP_FAIL;
      tia_pkg::CMD_GT:  item.op = rt_tag ? tia_pkg::OP_GT : tia_pkg::OP_FAIL;
      tia_pkg::CMD_LE:  item.op = rt_tag ? tia_pkg::OP_LE : tia_pkg::OP_FAIL;
      default:          item.op = tia_pkg::OP_FAIL;
    endcase
  end

endmodule
`default_nettype wire

[rtl/tia_queue.sv]
`default_nettype none
module tia_queue #(
  parameter int DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire tia_pkg::item_t push_item,
  input  wire                 pop,
  output tia_pkg::item_t      head_item,
  output logic                head_valid,
  output logic                full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tia_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item  = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == CW'(DEPTH));

endmodule
`default_nettype wire

[rtl/tia_back.sv]
`default_nettype none
module tia_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire tia_pkg::item_t head_item,
  input  wire                 head_valid,
  output logic                pop,
  output logic                out_valid,
  output tia_pkg::out_t       out_data
);

  tia_pkg::bk_state_t state_r, state_nxt;

  logic          out_valid_r, out_valid_nxt;
  tia_pkg::out_t out_r, out_nxt;

  // multiply operands and accumulator
  logic [63:0] ma_r, ma_nxt;
  logic [63:0] mb_r, mb_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  mul_cnt_r, mul_cnt_nxt;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] pp;
  logic [63:0] mul_sum;

  // divider registers
  logic [62:0] rem_r, rem_nxt;
  logic [62:0] quo_r, quo_nxt;
  logic [62:0] den_r, den_nxt;
  logic [5:0]  div_cnt_r, div_cnt_nxt;
  logic        neg_q_r, neg_q_nxt;
  logic        neg_r_r, neg_r_nxt;
  logic        is_mod_r, is_mod_nxt;
  logic [63:0] trial;
  logic [63:0] q_signed;
  logic [63:0] r_signed;

  // decoded head operands
  logic [63:0] dl;
  logic [63:0] dr;
  logic [63:0] abs_l;
  logic [63:0] abs_r;
  logic [63:0] shl_val;

  assign dl      = {head_item.left[63], head_item.left[63:1]};
  assign dr      = {head_item.right[63], head_item.right[63:1]};
  assign abs_l   = dl[63] ? (64'd0 - dl) : dl;
  assign abs_r   = dr[63] ? (64'd0 - dr) : dr;
  assign shl_val = dl << head_item.right[6:1];

  // shared 32x32 multiplier, low word of product from three partial products
  always_comb begin
    case (mul_cnt_r)
      2'd0:    begin mul_x = ma_r[31:0];  mul_y = mb_r[31:0];  end
      2'd1:    begin mul_x = ma_r[31:0];  mul_y = mb_r[63:32]; end
      default: begin mul_x = ma_r[63:32]; mul_y = mb_r[31:0];  end
    endcase
  end
  assign pp      = mul_x * mul_y;
  assign mul_sum = acc_r + {pp[31:0], 32'd0};

  // one restoring step
  assign trial    = {rem_r, quo_r[62]} - {1'b0, den_r};
  assign q_signed = neg_q_r ? (64'd0 - {1'b0, quo_r}) : {1'b0, quo_r};
  assign r_signed = neg_r_r ? (64'd0 - {1'b0, rem_r}) : {1'b0, rem_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tia_pkg::BK_RUN: begin
        if (head_valid) begin
          if (head_item.op == tia_pkg::OP_MUL) begin
            state_nxt = tia_pkg::BK_MUL;
          end else if (head_item.op == tia_pkg::OP_DIV || head_item.op == tia_pkg::OP_MOD) begin
            state_nxt = tia_pkg::BK_DIV;
          end
        end
      end
      tia_pkg::BK_MUL: begin
        if (mul_cnt_r == 2'(tia_pkg::MUL_STEPS - 1)) state_nxt = tia_pkg::BK_RUN;
      end
      tia_pkg::BK_DIV: begin
        if (div_cnt_r == 6'(tia_pkg::DIV_STEPS - 1)) state_nxt = tia_pkg::BK_FIX;
      end
      tia_pkg::BK_FIX: state_nxt = tia_pkg::BK_RUN;
      default:         state_nxt = tia_pkg::BK_RUN;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop           = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    acc_nxt       = acc_r;
    mul_cnt_nxt   = mul_cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    den_nxt       = den_r;
    div_cnt_nxt   = div_cnt_r;
    neg_q_nxt     = neg_q_r;
    neg_r_nxt     = neg_r_r;
    is_mod_nxt    = is_mod_r;
    case (state_r)
      tia_pkg::BK_RUN: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head_item.op)
            tia_pkg::OP_ADD: begin
              out_valid_nxt      = 1'b1;
              out_nxt.value_word = (head_item.left ^ 64'd1) + head_item.right;
            end
            tia_pkg::OP_SUB: begin
              out_valid_nxt      = 1'b1;
              out_nxt.value_word = (head_item.left - head_item.right) | 64'd1;
            end
            tia_pkg::OP_SHL: begin
              out_valid_nxt      = 1'b1;
              out_nxt.value_word = {shl_val[62:0], 1'b1};
            end
            tia_pkg::OP_LT: begin
              out_valid_nxt = 1'b1;
              out_nxt.truth = $signed(head_item.left) < $signed(head_item.right);
            end
            tia_pkg::OP_GT: begin
              out_valid_nxt = 1'b1;
              out_nxt.truth = $signed(head_item.right) < $signed(head_item.left);
            end
            tia_pkg::OP_LE: begin
              out_valid_nxt = 1'b1;
              out_nxt.truth = !($signed(head_item.right) < $signed(head_item.left));
            end
            tia_pkg::OP_MUL: begin
              ma_nxt      = dl;
              mb_nxt      = dr;
              acc_nxt     = '0;
              mul_cnt_nxt = '0;
            end
            tia_pkg::OP_DIV, tia_pkg::OP_MOD: begin
              rem_nxt     = '0;
              quo_nxt     = abs_l[62:0];
              den_nxt     = abs_r[62:0];
              div_cnt_nxt = '0;
              neg_q_nxt   = dl[63] ^ dr[63];
              neg_r_nxt   = dl[63];
              is_mod_nxt  = (head_item.op == tia_pkg::OP_MOD);
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_nxt.failed = 1'b1;
            end
          endcase
        end
      end
      tia_pkg::BK_MUL: begin
        mul_cnt_nxt = mul_cnt_r + 2'd1;
        if (mul_cnt_r == 2'd0) begin
          acc_nxt = pp;
        end else begin
          acc_nxt = mul_sum;
        end
        if (mul_cnt_r == 2'(tia_pkg::MUL_STEPS - 1)) begin
          out_valid_nxt      = 1'b1;
          out_nxt.value_word = {mul_sum[62:0], 1'b1};
        end
      end
      tia_pkg::BK_DIV: begin
        div_cnt_nxt = div_cnt_r + 6'd1;
        if (!trial[63]) begin
          rem_nxt = trial[62:0];
        end else begin
          rem_nxt = {rem_r[61:0], quo_r[62]};
        end
        quo_nxt = {quo_r[61:0], !trial[63]};
      end
      tia_pkg::BK_FIX: begin
        out_valid_nxt      = 1'b1;
        out_nxt.value_word = is_mod_r ? {r_signed[62:0], 1'b1} : {q_signed[62:0], 1'b1};
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tia_pkg::BK_RUN;
      out_valid_r <= 1'b0;
      mul_cnt_r   <= '0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mul_cnt_r   <= mul_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    den_r    <= den_nxt;
    neg_q_r  <= neg_q_nxt;
    neg_r_r  <= neg_r_nxt;
    is_mod_r <= is_mod_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // last multiply step strobes a result next cycle
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tia_pkg::BK_MUL && mul_cnt_r == 2'(tia_pkg::MUL_STEPS - 1)) |=> out_valid_r)
    else $error("multiply finished without result");

  // sign fixup strobes a result and frees the sequencer
  a_fix_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tia_pkg::BK_FIX) |=> (out_valid_r && state_r == tia_pkg::BK_RUN))
    else $error("divide finished without result");

  // nothing pops while a long operation runs
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tia_pkg::BK_RUN) |-> !pop)
    else $error("pop during long operation");

  // failed results carry zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.failed) |-> (out_r.value_word == 64'd0 && !out_r.truth))
    else $error("failed result with nonzero payload");

endmodule
`default_nettype wire

[rtl/tagged_integer_alu.sv]
`default_nettype none
// Path: add, sub, shift, compare and failed requests pass the request queue and output register;
// multiply adds partial products in the back end, divide and remainder use a restoring divider.
// Throughput: one request per cycle while busy is low; the back end takes no new request during a
// multiply, divide or remainder, and the request queue absorbs bursts.
// Reset: synchronous active-low rst_n empties the request queue and returns the back end to idle.
// Results cannot be stalled by the receiver; out_strobe marks each one for a single cycle.
module tagged_integer_alu #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire tia_pkg::in_t  in_req,
  output logic               out_strobe,
  output tia_pkg::out_t      out_result
);

  tia_pkg::item_t cls_item;
  tia_pkg::item_t head_item;
  logic           head_valid;
  logic           full;
  logic           pop;
  logic           push;

  assign push = start && !full;
  assign busy = full;

  tia_front u_front (
    .in_req (in_req),
    .item   (cls_item)
  );

  tia_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (cls_item),
    .pop        (pop),
    .head_item  (head_item),
    .head_valid (head_valid),
    .full       (full)
  );

  tia_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_strobe),
    .out_data   (out_result)
  );

endmodule
`default_nettype wire

[test/tagged_integer_alu_tb.sv]
`timescale 1ns / 100ps
module tagged_integer_alu_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tia_pkg::in_t in_req = '0;
  logic out_strobe;
  tia_pkg::out_t out_result;

  tia_pkg::out_t expected_results[$];
  int mismatches = 0;
  int sent_count = 0;
  int checked_count = 0;
  int fail_results = 0;
  longint unsigned cycle_count = 0;
  bit timed_out = 1'b0;

  always #2 clk = ~clk;

  tagged_integer_alu DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_strobe(out_strobe), .out_result(out_result)
  );

  // integer carried in a tagged word
  function automatic logic signed [63:0] untag_word(logic [63:0] w);
    return $signed(w) >>> 1;
  endfunction

  function automatic logic [63:0] tag_word(logic [63:0] n);
    return {n[62:0], 1'b1};
  endfunction

  // expected ALU outcome for one request
  function automatic tia_pkg::out_t alu_predict(tia_pkg::in_t req);
    tia_pkg::out_t res;
    logic [63:0] l, r;
    logic signed [63:0] a, b;
    logic lt, rt, bad;
    l = req.left_word;
    r = req.right_word;
    lt = l[0];
    rt = r[0];
    a = untag_word(l);
    b = untag_word(r);
    bad = 1'b0;
    res = '0;
    case (req.cmd)
      tia_pkg::CMD_ADD: if (lt && rt) res.value_word = (l ^ 64'd1) + r; else bad = 1'b1;
      tia_pkg::CMD_SUB: if (rt) res.value_word = (l - r) | 64'd1; else bad = 1'b1;
      tia_pkg::CMD_MUL: if (lt && rt) res.value_word = tag_word(a * b); else bad = 1'b1;
      tia_pkg::CMD_DIV, tia_pkg::CMD_MOD: begin
        if (!(lt && rt) || b == 0) bad = 1'b1;
        else if (req.cmd == tia_pkg::CMD_DIV) res.value_word = tag_word(a / b);
        else res.value_word = tag_word(a % b);
      end
      tia_pkg::CMD_SHL: begin
        if (!rt || b < 0 || b > 62) bad = 1'b1;
        else res.value_word = tag_word(a << b[5:0]);
      end
      tia_pkg::CMD_LT: if (rt) res.truth = $signed(l) < $signed(r); else bad = 1'b1;
      tia_pkg::CMD_GT: if (rt) res.truth = $signed(r) < $signed(l); else bad = 1'b1;
      tia_pkg::CMD_LE: if (rt) res.truth = !($signed(r) < $signed(l)); else bad = 1'b1;
      default: bad = 1'b1;
    endcase
    if (bad) res = '0;
    res.failed = bad;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_result);
      end else begin
        tia_pkg::out_t exp_res;
        exp_res = expected_results.pop_front();
        checked_count++;
        if (exp_res.failed) fail_results++;
        if (out_result !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value %h/%h truth %b/%b failed %b/%b (exp/act)",
                     exp_res.value_word, out_result.value_word, exp_res.truth,
                     out_result.truth, exp_res.failed, out_result.failed);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > 2000000 && !timed_out) begin
      timed_out = 1'b1;
      $display("timeout");
      $display("FAILURE");
      $finish;
    end
  end

  // random idle gap before a request, mostly short
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    repeat (n) @(negedge clk);
  endtask

  // send one request and record its expected result
  task automatic send_request(logic [3:0] cmd, logic [63:0] l, logic [63:0] r,
                              bit allow_gap = 1'b1);
    if (allow_gap) idle_gap();
    in_req.cmd = cmd;
    in_req.left_word = l;
    in_req.right_word = r;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(alu_predict(in_req));
    sent_count++;
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(0, 4))
      0: w = {$urandom, $urandom};
      1: w = {{54{1'($urandom_range(0, 1))}}, 10'd0} | 64'($urandom_range(0, 1023));
      2: w = 64'($signed($urandom_range(0, 40)) - 20) <<< 1;
      3: w = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom), $urandom};
      default: w = 64'($urandom_range(0, 200));
    endcase
    return w;
  endfunction

  function automatic logic [63:0] tagged_small(int lo, int hi);
    logic signed [63:0] n;
    n = $signed(64'($urandom_range(0, hi - lo))) + lo;
    return tag_word(n);
  endfunction

  task automatic test_extremes();
    logic [63:0] vals[6];
    vals = '{64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 64'd1, 64'h3,
             64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000};
    foreach (vals[i]) send_request(4'(tia_pkg::CMD_ADD + i % 3), vals[i], vals[5 - i]);
    send_request(tia_pkg::CMD_MUL, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(tia_pkg::CMD_DIV, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(tia_pkg::CMD_MOD, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_special_cases();
    send_request(tia_pkg::CMD_DIV, 64'd15, 64'd1);        // zero divisor
    send_request(tia_pkg::CMD_MOD, 64'd15, 64'd1);
    send_request(tia_pkg::CMD_DIV, -64'sd13, 64'd5);      // truncation toward zero
    send_request(tia_pkg::CMD_MOD, -64'sd13, 64'd5);
    send_request(tia_pkg::CMD_ADD, 64'd4, 64'd3);         // bad left tag
    send_request(tia_pkg::CMD_SUB, 64'd4, 64'd3);         // left tag not checked
    send_request(tia_pkg::CMD_LT, 64'd4, 64'd2);          // bad right tag
    send_request(tia_pkg::CMD_SHL, 64'd3, tag_word(64'(62)));  // shift edges
    send_request(tia_pkg::CMD_SHL, 64'd3, tag_word(64'(63)));
    send_request(tia_pkg::CMD_SHL, 64'd3, tag_word(64'(-1)));
    send_request(tia_pkg::CMD_GT, 64'd9, 64'd9);
    send_request(tia_pkg::CMD_LE, 64'd9, 64'd9);
    send_request(4'd9, 64'd1, 64'd1);            // unknown commands
    send_request(4'd15, 64'd1, 64'd1);
  endtask

  task automatic test_random(int count);
    logic [3:0] cmd;
    logic [63:0] l, r;
    repeat (count) begin
      cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
      l = rand_word();
      r = rand_word();
      // mostly well-formed operands so the arithmetic paths get exercised
      if ($urandom_range(0, 9) < 8) begin
        l[0] = 1'b1;
        r[0] = 1'b1;
      end
      if (cmd == tia_pkg::CMD_SHL && $urandom_range(0, 3) != 0) r = tagged_small(-2, 64);
      if ((cmd == tia_pkg::CMD_DIV || cmd == tia_pkg::CMD_MOD) && $urandom_range(0, 2) == 0)
        r = tagged_small(-9, 9);
      // some bursts with no gap at all
      send_request(cmd, l, r, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    int drain;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_special_cases();
    test_random(1425);
    drain = 0;
    while (expected_results.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (80) @(posedge clk);
    $display("%0d requests sent, %0d results checked (%0d failed-flag results)",
             sent_count, checked_count, fail_results);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
